@@ hw/rtl/tts_pkg.sv @@
// shared types and constants for the tick task scheduler table
`timescale 1ns / 1ps

package tts_pkg;

    // request codes
    localparam logic [1:0] REQ_ADD      = 2'd0;
    localparam logic [1:0] REQ_DELETE   = 2'd1;
    localparam logic [1:0] REQ_TICK     = 2'd2;
    localparam logic [1:0] REQ_DISPATCH = 2'd3;

    // result kinds
    localparam logic [2:0] KIND_ADDED   = 3'd0;
    localparam logic [2:0] KIND_FULL    = 3'd1;
    localparam logic [2:0] KIND_DELETED = 3'd2;
    localparam logic [2:0] KIND_TICK    = 3'd3;
    localparam logic [2:0] KIND_RUN     = 3'd4;
    localparam logic [2:0] KIND_NONE    = 3'd5;

    // run results per dispatch and the width of their count
    localparam int MAX_RESULTS = 8;
    localparam int RUN_CNT_W   = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] PENDING_MAX = 8'hFF;

    // input beat
    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] task_id;
        logic [15:0] start_delay;
        logic [15:0] repeat_period;
        logic [2:0]  slot_index;
    } req_t;

    // result beat
    typedef struct packed {
        logic [2:0]  result_kind;
        logic [2:0]  slot_out;
        logic [15:0] run_task_id;
        logic        last_result;
    } res_t;

    // one task slot
    typedef struct packed {
        logic [15:0] task_id;
        logic [15:0] delay;
        logic [15:0] period;
        logic [7:0]  pending;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd_en;
        logic proc;
        logic fin;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic stop;
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

endpackage

@@ hw/rtl/tts_ctrl.sv @@
// controller: walks the slot table one slot per cycle
`timescale 1ns / 1ps

module tts_ctrl #(
    parameter  int MAX_TASKS = 8,
    localparam int SW        = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           op,
    input  tts_pkg::status_t     status,
    output tts_pkg::cmd_t        cmd,
    output logic [SW-1:0]        rd_addr,
    output logic                 busy
);

    localparam int CW = $clog2(MAX_TASKS + 1);

    tts_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    // state and slot counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tts_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        rd_addr    = cnt_reg[SW-1:0];
        busy       = 1'b1;
        case (state_reg)
            tts_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (op != tts_pkg::REQ_DELETE)
                    begin
                        cmd.rd_en  = 1'b1;
                        rd_addr    = '0;
                        cnt_next   = CW'(1);
                        state_next = tts_pkg::ST_WALK;
                    end
                end
            end
            tts_pkg::ST_WALK:
            begin
                cmd.proc = 1'b1;
                if (status.stop || cnt_reg == CW'(MAX_TASKS))
                begin
                    state_next = tts_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    cnt_next  = cnt_reg + CW'(1);
                end
            end
            tts_pkg::ST_FINISH:
            begin
                cmd.fin    = 1'b1;
                state_next = tts_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tts_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/tts_datapath.sv @@
// datapath: slot memory, per-slot update and result register
`timescale 1ns / 1ps

module tts_datapath #(
    parameter  int MAX_TASKS = 8,
    localparam int SW        = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tts_pkg::req_t        request,
    input  tts_pkg::cmd_t        cmd,
    input  logic [SW-1:0]        rd_addr,
    output tts_pkg::status_t     status,
    output logic                 strobe,
    output tts_pkg::res_t        result
);

    tts_pkg::entry_t mem [MAX_TASKS];
    logic [MAX_TASKS-1:0] valid_reg, valid_next;

    tts_pkg::req_t   req_reg;
    tts_pkg::entry_t rd_data_reg;
    logic            rd_vld_reg;
    logic [SW-1:0]   proc_addr_reg;

    tts_pkg::res_t   held_reg, held_next;
    logic            held_vld_reg, held_vld_next;
    logic [tts_pkg::RUN_CNT_W-1:0] run_cnt_reg, run_cnt_next;

    tts_pkg::res_t   out_reg, out_next;
    logic            strobe_reg, strobe_next;

    logic            mem_we;
    tts_pkg::entry_t mem_wd;
    tts_pkg::entry_t cur;
    logic            occ;
    logic            ready;

    // latched request
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
    end

    // slot memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[proc_addr_reg] <= mem_wd;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg   <= mem[rd_addr];
            proc_addr_reg <= rd_addr;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            held_vld_reg <= 1'b0;
            run_cnt_reg  <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            if (cmd.rd_en)
            begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
            held_vld_reg <= held_vld_next;
            run_cnt_reg  <= run_cnt_next;
            strobe_reg   <= strobe_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
        out_reg  <= out_next;
    end

    // slot under processing; a slot never written reads as empty
    always_comb
    begin
        cur   = rd_vld_reg ? rd_data_reg : '0;
        occ   = (cur.task_id != 16'd0);
        ready = occ && (cur.pending != 8'd0);
    end

    // per-slot update and result sequencing
    always_comb
    begin
        valid_next    = valid_reg;
        mem_we        = 1'b0;
        mem_wd        = cur;
        held_next     = held_reg;
        held_vld_next = held_vld_reg;
        run_cnt_next  = run_cnt_reg;
        out_next      = out_reg;
        strobe_next   = 1'b0;
        status.stop   = 1'b0;

        // new request: clear held result, delete finishes at once
        if (cmd.load)
        begin
            held_vld_next = 1'b0;
            run_cnt_next  = '0;
            if (request.req_type == tts_pkg::REQ_DELETE)
            begin
                if (int'(request.slot_index) < MAX_TASKS)
                begin
                    valid_next[SW'(request.slot_index)] = 1'b0;
                end
                strobe_next          = 1'b1;
                out_next.result_kind = tts_pkg::KIND_DELETED;
                out_next.slot_out    = request.slot_index;
                out_next.run_task_id = 16'd0;
                out_next.last_result = 1'b1;
            end
        end

        // one slot of the walk
        if (cmd.proc)
        begin
            case (req_reg.req_type)
                tts_pkg::REQ_ADD:
                begin
                    if (!occ)
                    begin
                        mem_we                   = 1'b1;
                        mem_wd.task_id           = req_reg.task_id;
                        mem_wd.delay             = req_reg.start_delay;
                        mem_wd.period            = req_reg.repeat_period;
                        mem_wd.pending           = 8'd0;
                        valid_next[proc_addr_reg] = 1'b1;
                        held_vld_next            = 1'b1;
                        held_next.result_kind    = tts_pkg::KIND_ADDED;
                        held_next.slot_out       = 3'(proc_addr_reg);
                        held_next.run_task_id    = 16'd0;
                        held_next.last_result    = 1'b0;
                        status.stop              = 1'b1;
                    end
                end
                tts_pkg::REQ_TICK:
                begin
                    if (occ)
                    begin
                        mem_we = 1'b1;
                        if (cur.delay == 16'd0)
                        begin
                            if (cur.pending != tts_pkg::PENDING_MAX)
                            begin
                                mem_wd.pending = cur.pending + 8'd1;
                            end
                            if (cur.period != 16'd0)
                            begin
                                mem_wd.delay = cur.period - 16'd1;
                            end
                        end
                        else
                        begin
                            mem_wd.delay = cur.delay - 16'd1;
                        end
                    end
                end
                tts_pkg::REQ_DISPATCH:
                begin
                    if (ready)
                    begin
                        // one-shot slots leave the table after their run
                        if (cur.period == 16'd0)
                        begin
                            valid_next[proc_addr_reg] = 1'b0;
                        end
                        else
                        begin
                            mem_we         = 1'b1;
                            mem_wd.pending = cur.pending - 8'd1;
                        end
                        // the earlier run is not the last one
                        if (held_vld_reg)
                        begin
                            strobe_next          = 1'b1;
                            out_next             = held_reg;
                            out_next.last_result = 1'b0;
                        end
                        held_vld_next         = 1'b1;
                        held_next.result_kind = tts_pkg::KIND_RUN;
                        held_next.slot_out    = 3'(proc_addr_reg);
                        held_next.run_task_id = cur.task_id;
                        held_next.last_result = 1'b0;
                        run_cnt_next          = run_cnt_reg + tts_pkg::RUN_CNT_W'(1);
                        if (run_cnt_reg == tts_pkg::RUN_CNT_W'(tts_pkg::MAX_RESULTS - 1))
                        begin
                            status.stop = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        // closing beat of the request
        if (cmd.fin)
        begin
            strobe_next          = 1'b1;
            out_next.slot_out    = 3'd0;
            out_next.run_task_id = 16'd0;
            out_next.last_result = 1'b1;
            case (req_reg.req_type)
                tts_pkg::REQ_ADD:
                begin
                    if (held_vld_reg)
                    begin
                        out_next.result_kind = tts_pkg::KIND_ADDED;
                        out_next.slot_out    = held_reg.slot_out;
                    end
                    else
                    begin
                        out_next.result_kind = tts_pkg::KIND_FULL;
                    end
                end
                tts_pkg::REQ_DISPATCH:
                begin
                    if (held_vld_reg)
                    begin
                        out_next             = held_reg;
                        out_next.last_result = 1'b1;
                    end
                    else
                    begin
                        out_next.result_kind = tts_pkg::KIND_NONE;
                    end
                end
                default:
                begin
                    out_next.result_kind = tts_pkg::KIND_TICK;
                end
            endcase
        end
    end

    assign strobe = strobe_reg;
    assign result = out_reg;

endmodule

@@ hw/rtl/tick_task_scheduler_table.sv @@
// top level of the tick task scheduler table
//
//   channel   ports                   handshake
//   request   start, busy, request    beat taken when start is high and busy is low
//   result    strobe, result          beat shown for one cycle, always taken
//
// delete: the result beat follows the accept edge and busy stays low.
// add, tick, dispatch: the controller reads one slot a cycle from the slot memory;
// add stops at the first free slot, dispatch after its eighth run beat.
// reset clears the slot valid bits at once; there is no clearing pass.
// results cannot be held off; run beats of a dispatch come out as the walk finds them.
`timescale 1ns / 1ps

module tick_task_scheduler_table #(
    parameter int MAX_TASKS = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  tts_pkg::req_t  request,
    output logic           strobe,
    output tts_pkg::res_t  result
);

    localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    tts_pkg::cmd_t    cmd;
    tts_pkg::status_t status;
    logic [SW-1:0]    rd_addr;

    // controller
    tts_ctrl #(
        .MAX_TASKS (MAX_TASKS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .op      (request.req_type),
        .status  (status),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .busy    (busy)
    );

    // datapath
    tts_datapath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .status  (status),
        .strobe  (strobe),
        .result  (result)
    );

endmodule

@@ hw/rtl/tts_check.sv @@
// port checks for the tick task scheduler table and their bind
`timescale 1ns / 1ps

module tts_check (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input tts_pkg::req_t  request,
    input logic           strobe,
    input tts_pkg::res_t  result
);

    // a walking request keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.req_type != tts_pkg::REQ_DELETE) |=> busy)
        else $error("walking request did not raise busy");

    // delete answers with a single closing beat in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.req_type == tts_pkg::REQ_DELETE) |=>
        (strobe && result.last_result && result.result_kind == tts_pkg::KIND_DELETED))
        else $error("delete beat missing");

    // leaving busy comes with the closing beat
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (strobe && result.last_result))
        else $error("busy dropped without a closing beat");

    // only run beats are followed by more beats of the same request
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.last_result) |-> (result.result_kind == tts_pkg::KIND_RUN))
        else $error("non-run beat without last flag");

endmodule

bind tick_task_scheduler_table tts_check u_tts_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .strobe  (strobe),
    .result  (result)
);

@@ tb/tick_task_scheduler_table_checker.sv @@
// checker for the tick task scheduler table: slot table predictor and result compare
`timescale 1ns / 1ps

module tick_task_scheduler_table_checker #(
    parameter int SLOTS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  tts_pkg::req_t request,
    input  logic          strobe,
    input  tts_pkg::res_t result,
    output int            errors,
    output int            outstanding
);

    // predicted slot table
    logic [15:0] sl_task    [SLOTS];
    logic [15:0] sl_delay   [SLOTS];
    logic [15:0] sl_period  [SLOTS];
    logic [7:0]  sl_pending [SLOTS];

    // result beats still to come, oldest first
    tts_pkg::res_t due_beats[$];
    int            err_cnt = 0;

    function automatic tts_pkg::res_t make_beat(logic [2:0] kind, logic [2:0] slot,
                                                logic [15:0] id);
        tts_pkg::res_t b;
        b.result_kind = kind;
        b.slot_out    = slot;
        b.run_task_id = id;
        b.last_result = 1'b0;
        return b;
    endfunction

    function automatic void clear_entry(int s);
        sl_task[s]    = '0;
        sl_delay[s]   = '0;
        sl_period[s]  = '0;
        sl_pending[s] = '0;
    endfunction

    // advance the slot table by one request and queue the beats it causes
    function automatic void predict_request(tts_pkg::req_t r);
        tts_pkg::res_t batch[$];
        tts_pkg::res_t tail;
        int            s;
        int            runs;
        runs = 0;
        case (r.req_type)
            tts_pkg::REQ_ADD:
            begin
                s = 0;
                while (s < SLOTS && sl_task[s] != 0)
                    s++;
                if (s >= SLOTS)
                    batch.push_back(make_beat(tts_pkg::KIND_FULL, 3'd0, 16'd0));
                else
                begin
                    sl_task[s]    = r.task_id;
                    sl_delay[s]   = r.start_delay;
                    sl_period[s]  = r.repeat_period;
                    sl_pending[s] = '0;
                    batch.push_back(make_beat(tts_pkg::KIND_ADDED, 3'(s), 16'd0));
                end
            end
            tts_pkg::REQ_DELETE:
            begin
                if (int'(r.slot_index) < SLOTS)
                    clear_entry(int'(r.slot_index));
                batch.push_back(make_beat(tts_pkg::KIND_DELETED, r.slot_index, 16'd0));
            end
            tts_pkg::REQ_TICK:
            begin
                for (s = 0; s < SLOTS; s++)
                begin
                    if (sl_task[s] != 0)
                    begin
                        if (sl_delay[s] == 0)
                        begin
                            if (sl_pending[s] != tts_pkg::PENDING_MAX)
                                sl_pending[s] = sl_pending[s] + 8'd1;
                            if (sl_period[s] != 0)
                                sl_delay[s] = sl_period[s] - 16'd1;
                        end
                        else
                            sl_delay[s] = sl_delay[s] - 16'd1;
                    end
                end
                batch.push_back(make_beat(tts_pkg::KIND_TICK, 3'd0, 16'd0));
            end
            default:
            begin
                // dispatch: one run beat per ready slot, capped per request
                for (s = 0; s < SLOTS && runs < tts_pkg::MAX_RESULTS; s++)
                begin
                    if (sl_task[s] != 0 && sl_pending[s] != 0)
                    begin
                        batch.push_back(make_beat(tts_pkg::KIND_RUN, 3'(s), sl_task[s]));
                        runs++;
                        sl_pending[s] = sl_pending[s] - 8'd1;
                        // one-shot task leaves the table even with runs left
                        if (sl_period[s] == 0)
                            clear_entry(s);
                    end
                end
                if (runs == 0)
                    batch.push_back(make_beat(tts_pkg::KIND_NONE, 3'd0, 16'd0));
            end
        endcase
        tail = batch[batch.size() - 1];
        tail.last_result = 1'b1;
        batch[batch.size() - 1] = tail;
        foreach (batch[i])
            due_beats.push_back(batch[i]);
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endfunction

    // compare result beats first, then predict the request taken at this edge
    always @(posedge clk or negedge rst_n)
    begin
        tts_pkg::res_t want;
        if (!rst_n)
        begin
            for (int s = 0; s < SLOTS; s++)
                clear_entry(s);
            due_beats.delete();
            outstanding <= 0;
        end
        else
        begin
            if (strobe)
            begin
                if (due_beats.size() == 0)
                begin
                    $error("result beat with none expected: kind %0d slot %0d id %0h",
                           result.result_kind, result.slot_out, result.run_task_id);
                    err_cnt++;
                end
                else
                begin
                    want = due_beats.pop_front();
                    check_field("result_kind", 16'(want.result_kind), 16'(result.result_kind));
                    check_field("slot_out", 16'(want.slot_out), 16'(result.slot_out));
                    check_field("run_task_id", want.run_task_id, result.run_task_id);
                    check_field("last_result", 16'(want.last_result), 16'(result.last_result));
                end
            end
            if (start && !busy)
                predict_request(request);
            outstanding <= due_beats.size();
        end
        errors <= err_cnt;
    end

endmodule

@@ tb/tick_task_scheduler_table_test.sv @@
// stimulus and verdict for the tick task scheduler table
`timescale 1ns / 1ps

module tick_task_scheduler_table_test;

    localparam int SLOTS      = 8;
    localparam int IDLE_LIMIT = 2000;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    tts_pkg::req_t request;
    logic          strobe;
    tts_pkg::res_t result;
    int            errors;
    int            outstanding;
    int            quiet_cycles;

    tick_task_scheduler_table #(
        .MAX_TASKS(SLOTS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .request(request),
        .strobe (strobe),
        .result (result)
    );

    tick_task_scheduler_table_checker #(
        .SLOTS(SLOTS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .strobe     (strobe),
        .result     (result),
        .errors     (errors),
        .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: cycles with no beat moving in either direction
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic tts_pkg::req_t make_req(logic [1:0] kind, logic [15:0] id,
                                               logic [15:0] dly, logic [15:0] per,
                                               logic [2:0] idx);
        tts_pkg::req_t r;
        r.req_type      = kind;
        r.task_id       = id;
        r.start_delay   = dly;
        r.repeat_period = per;
        r.slot_index    = idx;
        return r;
    endfunction

    // request whose unused fields carry random noise
    function automatic tts_pkg::req_t noisy_req(logic [1:0] kind);
        return make_req(kind, 16'($urandom), 16'($urandom), 16'($urandom), 3'($urandom));
    endfunction

    // one request beat, with an optional idle gap ahead of it
    task automatic send(tts_pkg::req_t r, int idle_pct);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            start   <= 1'b0;
            request <= noisy_req(2'($urandom));
            repeat ($urandom_range(0, 3)) @(negedge clk);
        end
        @(negedge clk);
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // hold off until every expected result beat has come
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        @(posedge clk);
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // random request, weighted toward sequences that make tasks run
    task automatic send_random(int idle_pct);
        int          pick;
        logic [15:0] id;
        logic [15:0] dly;
        logic [15:0] per;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            id  = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(1, 16'hFFFF));
            dly = ($urandom_range(0, 15) < 12) ? 16'($urandom_range(0, 4)) : 16'($urandom);
            pick = $urandom_range(0, 15);
            if (pick < 5)
                per = 16'd0;
            else if (pick < 13)
                per = 16'($urandom_range(1, 4));
            else
                per = 16'($urandom);
            send(make_req(tts_pkg::REQ_ADD, id, dly, per, 3'($urandom)), idle_pct);
        end
        else if (pick < 45)
            send(noisy_req(tts_pkg::REQ_DELETE), idle_pct);
        else if (pick < 80)
            send(noisy_req(tts_pkg::REQ_TICK), idle_pct);
        else
            send(noisy_req(tts_pkg::REQ_DISPATCH), idle_pct);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        request      = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, id and timing extremes, one-shot removal
        send(make_req(tts_pkg::REQ_DISPATCH, 16'd0, 16'd0, 16'd0, 3'd0), 0);
        send(make_req(tts_pkg::REQ_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7), 0);
        send(make_req(tts_pkg::REQ_ADD, 16'hFFFF, 16'd0, 16'd0, 3'd0), 0);
        // id zero is written but the slot still reads as free
        send(make_req(tts_pkg::REQ_ADD, 16'd0, 16'hFFFF, 16'hFFFF, 3'd7), 0);
        send(make_req(tts_pkg::REQ_ADD, 16'd1, 16'hFFFF, 16'hFFFF, 3'd0), 0);
        send(make_req(tts_pkg::REQ_ADD, 16'h1234, 16'd0, 16'd1, 3'd0), 0);
        send(make_req(tts_pkg::REQ_ADD, 16'h00FF, 16'd1, 16'd2, 3'd0), 0);
        send(make_req(tts_pkg::REQ_TICK, 16'd0, 16'd0, 16'd0, 3'd0), 0);
        send(make_req(tts_pkg::REQ_TICK, 16'd0, 16'd0, 16'd0, 3'd0), 0);
        // one-shot with two runs pending leaves after its first run
        send(make_req(tts_pkg::REQ_DISPATCH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7), 0);
        send(make_req(tts_pkg::REQ_DELETE, 16'd0, 16'd0, 16'd0, 3'd2), 0);
        send(make_req(tts_pkg::REQ_DELETE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7), 0);
        send(make_req(tts_pkg::REQ_DELETE, 16'd0, 16'd0, 16'd0, 3'd0), 0);
        // fill the table, then one add too many
        for (int i = 0; i < 7; i++)
            send(make_req(tts_pkg::REQ_ADD, 16'(16'h8000 + i), 16'(i % 2), 16'(i % 3),
                          3'(i)), 0);
        send(make_req(tts_pkg::REQ_TICK, 16'd0, 16'd0, 16'd0, 3'd0), 0);
        send(make_req(tts_pkg::REQ_DISPATCH, 16'd0, 16'd0, 16'd0, 3'd0), 0);
        send(make_req(tts_pkg::REQ_DISPATCH, 16'd0, 16'd0, 16'd0, 3'd0), 0);
        send(make_req(tts_pkg::REQ_TICK, 16'd0, 16'd0, 16'd0, 3'd0), 0);

        // random, no idling
        repeat (30) send_random(0);
        drain();

        // random, sender idle about half the time
        repeat (30) send_random(53);
        drain();

        // pending count saturation: one periodic task ready on every tick
        // in slot 0; two dispatches tell a saturated count from a wrapped one
        send(make_req(tts_pkg::REQ_DELETE, 16'd0, 16'd0, 16'd0, 3'd0), 31);
        send(make_req(tts_pkg::REQ_ADD, 16'hA5A5, 16'd0, 16'd1, 3'($urandom)), 31);
        repeat (257) send(noisy_req(tts_pkg::REQ_TICK), 31);
        repeat (2) send(noisy_req(tts_pkg::REQ_DISPATCH), 31);
        drain();

        // random, sender idle about a third of the time
        repeat (10) send_random(31);

        // wait out the last result beats, then a few quiet cycles
        drain();
        repeat (20) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
